/* rtl/core/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // Input integer width and derived sizes
    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
    // floor(W * log10(2)) + 1 decimal digits cover any magnitude up to 2^(W-1)
    localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W       = NUM_DIGITS * 4;
    localparam int CNT_W       = $clog2(NUM_DIGITS + 1);
    localparam int BIT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int CHAR_W      = 8;
    localparam int OUT_DATA_W  = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGITS
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic cnt_one;
        logic is_zero;
        logic out_free;
    } status_t;

endpackage

/* rtl/core/sitda_dp.sv */
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude/BCD shift registers, digit and bit counters, output register.
// ----------------------------------------------------------------------------
module sitda_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [sitda_pkg::VALUE_WIDTH-1:0]    in_value,
    input  sitda_pkg::cmd_t                      cmd,
    output sitda_pkg::status_t                   sts,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sitda_pkg::CHAR_W-1:0]         out_char,
    output logic                                 out_last
);
    import sitda_pkg::*;

    logic [VALUE_WIDTH-1:0] mag_reg,     mag_next;
    logic [BCD_W-1:0]       bcd_reg,     bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg,     cnt_next;
    logic [BIT_W-1:0]       bitcnt_reg,  bitcnt_next;
    logic                   neg_reg,     neg_next;
    logic                   zero_reg,    zero_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg,  out_char_next;
    logic                   out_last_reg,  out_last_next;
    logic [3:0]             top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Double-dabble correction: +3 on every digit of 5 or more
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        bitcnt_next    = bitcnt_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (cmd.load) begin
            neg_next    = in_value[VALUE_WIDTH-1];
            zero_next   = (in_value == '0);
            // two's complement magnitude; most negative value maps to 2^(W-1)
            mag_next    = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
            bcd_next    = '0;
            bitcnt_next = BIT_W'(VALUE_WIDTH);
            cnt_next    = CNT_W'(NUM_DIGITS);
        end

        if (cmd.conv_step) begin
            bcd_next    = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next    = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bitcnt_next = bitcnt_reg - 1'b1;
        end

        if (cmd.skip_step || cmd.emit_digit) begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.emit_sign) begin
            out_valid_next = 1'b1;
            out_char_next  = neg_reg ? CH_MINUS : CH_SPACE;
            out_last_next  = 1'b0;
        end

        if (cmd.emit_digit) begin
            out_valid_next = 1'b1;
            out_char_next  = CH_ZERO + {4'b0000, top_digit};
            out_last_next  = sts.cnt_one;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        bitcnt_reg   <= bitcnt_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign sts.conv_done = (bitcnt_reg == '0);
    assign sts.top_zero  = (top_digit == 4'd0);
    assign sts.cnt_one   = (cnt_reg == CNT_W'(1));
    assign sts.is_zero   = zero_reg;
    assign sts.out_free  = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    // a converted digit is always a valid BCD digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |=> (out_char_reg >= CH_ZERO) && (out_char_reg <= CH_NINE))
        else $error("emitted digit out of range");

    // leading-zero skip never consumes the final digit
    a_skip_keeps_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.skip_step |-> !sts.cnt_one)
        else $error("skipped the last digit");

    // load arms the bit counter for a full conversion
    a_load_bitcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (bitcnt_reg == BIT_W'(VALUE_WIDTH)) && (bcd_reg == '0))
        else $error("conversion not armed on load");
`endif

endmodule

/* rtl/core/sitda_ctrl.sv */
// ----------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences load, conversion, zero skip and character emission.
// ----------------------------------------------------------------------------
module sitda_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sitda_pkg::status_t  sts,
    output sitda_pkg::cmd_t     cmd
);
    import sitda_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_CONV;
            end
            S_CONV: begin
                if (sts.conv_done) state_next = S_SKIP;
            end
            S_SKIP: begin
                if (!(sts.top_zero && !sts.cnt_one)) state_next = S_SIGN;
            end
            S_SIGN: begin
                if (sts.is_zero || sts.out_free) state_next = S_DIGITS;
            end
            S_DIGITS: begin
                if (sts.out_free && sts.cnt_one) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CONV: begin
                cmd.conv_step = ~sts.conv_done;
            end
            S_SKIP: begin
                cmd.skip_step = sts.top_zero & ~sts.cnt_one;
            end
            S_SIGN: begin
                cmd.emit_sign = ~sts.is_zero & sts.out_free;
            end
            S_DIGITS: begin
                cmd.emit_digit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // characters only go out when the output register can take them
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
        else $error("character emitted into a full output register");

    // a zero input collapses to the single digit '0' before the sign step
    a_zero_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SIGN && sts.is_zero) |-> (sts.top_zero && sts.cnt_one))
        else $error("zero input did not reduce to one digit");

    // a fresh conversion starts with bits still to shift
    a_conv_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CONV && $past(state_reg) == S_IDLE) |-> !sts.conv_done)
        else $error("conversion started without bits to shift");
`endif

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per integer, s_tdata[VALUE_WIDTH-1:0] two's complement.
//   m_ channel: one item per character, m_tdata[7:0] ASCII, m_tlast on the
//   final character of each integer. Zero gives "0"; any other value gives a
//   sign character ('-' or space) and then the digits without leading zeros.
// Timing:
//   Conversion is a bit-serial double dabble, one input bit per cycle. After
//   the accepting edge an item goes through conversion, then drops its
//   leading zero digits, then passes the sign step (a zero input sends no
//   sign) and then sends its digits. Dropped zeros plus digits always
//   total NUM_DIGITS. s_tready is high only between items; the next item
//   can be taken while the last character still sits in the output
//   register.
// Reset: aresetn (synchronous, active low) drops any item in flight and
//   empties the output register.
// Stall: a low m_tready holds the current character and freezes emission;
//   no character is lost or repeated.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sitda_pkg::DATA_W-1:0]     s_tdata,   // [VALUE_WIDTH-1:0] value
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sitda_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] char_code
    output logic                             m_tlast    // last_char
);
    import sitda_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // sequencing
    sitda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // shift registers, counters and output register
    sitda_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

/* tb/sv/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed integer to decimal ASCII formatter.
// Every integer taken on the s_ channel is turned into its expected text in
// the bench. Each character on the m_ channel is checked in order against
// that text. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
    import sitda_pkg::*;

    localparam int VW         = VALUE_WIDTH;
    localparam int LONG_HOLD  = 400;     // receiver hold-off, in cycles
    localparam int HOLD_AFTER = 60;      // characters checked before the hold-off
    localparam int RAND_ITEMS = 360;
    localparam int TAIL       = 120;     // cycles after the last character

    // One expected character: ASCII code plus end-of-text flag
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // ------------------------------------------------------------------------
    // Text scoreboard: builds expected text per integer, checks characters
    // ------------------------------------------------------------------------
    class text_scoreboard;
        text_char_t pending_text[$];
        int         errors;
        int         chars_checked;

        // Expected decimal text of one integer
        function void note_value(logic [VW-1:0] value);
            logic [VW-1:0] magnitude;
            logic          negative;
            logic [3:0]    digits[$];
            text_char_t    c;
            if (value == '0) begin
                c.code = CH_ZERO;
                c.last = 1'b1;
                pending_text.push_back(c);
                return;
            end
            negative = value[VW-1];
            // Two's-complement magnitude; the most negative value wraps to
            // 2^(VW-1) in an unsigned VW-bit vector, which is exact.
            magnitude = negative ? (~value + 1'b1) : value;
            while (magnitude != '0) begin
                digits.push_front(4'(magnitude % VW'(10)));
                magnitude = magnitude / VW'(10);
            end
            c.code = negative ? CH_MINUS : CH_SPACE;
            c.last = 1'b0;
            pending_text.push_back(c);
            foreach (digits[i]) begin
                c.code = CH_ZERO + CHAR_W'(digits[i]);
                c.last = (i == digits.size() - 1);
                pending_text.push_back(c);
            end
        endfunction

        // Compare one received character with the oldest expected one
        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_char_t want;
            chars_checked++;
            if (pending_text.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected char code=%h last=%b", $realtime, code, last);
                return;
            end
            want = pending_text.pop_front();
            if (want.code !== code || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: char mismatch: expected code=%h last=%b, got code=%h last=%b",
                             $realtime, want.code, want.last, code, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;     // [VW-1:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [7:0] char_code
    logic                  m_tlast;           // last_char

    text_scoreboard sb;
    logic           calm = 1'b0;              // set: neither side idles
    logic           hold_done = 1'b0;

    always #10 aclk = ~aclk;

    signed_int_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VW-1:0] pow10(int n);
        logic [VW-1:0] p;
        p = 1;
        repeat (n) p = p * VW'(10);
        return p;
    endfunction

    // Random integer; weighted toward short magnitudes and digit-count edges
    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        int            r;
        int            k;
        r = $urandom_range(0, 9);
        v = VW'({$urandom, $urandom});
        case (r)
            4, 5, 6: begin
                // magnitude of random bit length, random sign
                k = $urandom_range(1, VW - 1);
                v = v & ((VW'(1) << k) - 1'b1);
                if ($urandom_range(0, 1)) v = -v;
            end
            7: begin
                // around a power of ten: digit count changes here
                v = pow10($urandom_range(1, 9)) + VW'($urandom_range(0, 2)) - 1'b1;
                if ($urandom_range(0, 1)) v = -v;
            end
            8: begin
                // near the ends of the range
                if ($urandom_range(0, 1))
                    v = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
                else
                    v = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
            end
            9: begin
                // zero or a single digit either side
                v = VW'($urandom_range(0, 9));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: ;
        endcase
        return v;
    endfunction

    // Offer one integer and hold it until the block takes it. Valid is left
    // high; the caller decides whether the next item follows back to back.
    task automatic send_value(logic [VW-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(value);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_value(value);
    endtask

    task automatic sender_gap();
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until all expected text is out
    task automatic drain_text();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_text.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result monitor: values sampled at the edge, before the block updates
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_char(m_tdata, m_tlast);
    end

    // ------------------------------------------------------------------------
    // Receiver: random backpressure, one long hold-off while the sender
    // keeps offering so the block fills and stalls its input
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && sb.chars_checked >= HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                stall = calm ? 0 : pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [VW-1:0] directed[$];
        sb = new;

        // Reset held low at the start, released once
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero, +-1, digit-count edges, range ends (most negative
        // included), alternating bit patterns, all-ones (-1) and zero cover
        // every input bit.
        directed = '{
            VW'(0), VW'(1), -VW'(1), VW'(9), VW'(10), -VW'(10), VW'(99), VW'(100),
            {1'b0, {(VW-1){1'b1}}}, {1'b1, {(VW-1){1'b0}}},
            {1'b1, {(VW-2){1'b0}}, 1'b1}, {1'b0, {(VW-2){1'b1}}, 1'b0},
            pow10(9), -pow10(9), pow10(9) - 1'b1, -(pow10(9) - 1'b1),
            {(VW/2){2'b01}}, {(VW/2){2'b10}},
            VW'(1234567890), -VW'(1234567890), VW'(7), -VW'(9), VW'(1000)
        };
        foreach (directed[i]) begin
            send_value(directed[i]);
            sender_gap();
        end

        // Sender pause: everything out before the random part
        drain_text();

        // Random part, in stretches of 40; some stretches run without idling
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == RAND_ITEMS / 2)
                drain_text();
            send_value(random_value());
            sender_gap();
        end
        calm = 1'b0;

        drain_text();
        repeat (TAIL) @(posedge aclk);

        if (sb.errors == 0 && sb.pending_text.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far above the slowest correct run
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
